@@ src/rv32se_pkg.sv @@
package rv32se_pkg;

	// Defaults
	localparam int unsigned REG_COUNT_DEF = 32;

	// Major opcodes
	localparam logic [6:0] OPC_R = 7'h33;
	localparam logic [6:0] OPC_I = 7'h13;
	localparam logic [6:0] OPC_B = 7'h63;
	localparam logic [6:0] OPC_J = 7'h6F;

	// funct7 codes
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_SUB  = 7'h20;

	// ALU funct3 codes (R and I type)
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;

	// Branch funct3 codes
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_WORDS = 1'b1;

	// Result of one executed instruction
	typedef struct packed {
		logic [31:0] next_pc;
		logic        write_enable;
		logic [4:0]  write_index;
		logic [31:0] write_value;
		logic        branch_taken;
		logic        unsupported;
		logic        done_res;
	} exec_res_t;

endpackage

@@ src/rv32i_subset_executor_core.sv @@
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------------
// in        | input     | in_valid / in_stall    | instruction_word
// out       | output    | out_valid / out_stall  | next_pc, write_enable, write_index,
//           |           |                        | write_value, branch_taken, unsupported,
//           |           |                        | done_res
// cfg       | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Requests pass the execute stage registers, then the result register; one is taken every
// cycle unless in_stall is high. The operand read takes both sources from the synchronous
// register file memory, forwarding a write in flight; execute writes back, updates the PC.
// Reset clears the register file valid bits (unwritten entries read as zero) and the PC.
// An output stall holds the result register and backs up into the execute stage.
module rv32i_subset_executor_core #(
	parameter int unsigned REG_COUNT = rv32se_pkg::REG_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// instruction channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      instruction_word,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [31:0]                      next_pc,
	output logic                             write_enable,
	output logic [4:0]                       write_index,
	output logic [31:0]                      write_value,
	output logic                             branch_taken,
	output logic                             unsupported,
	output logic                             done_res,
	// configuration channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rv32se_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int unsigned IDX_W = $clog2(REG_COUNT);
	localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

	// Handshake control
	logic s1_vld_q;
	logic out_vld_q;
	logic out_free;
	logic s1_fire;
	logic in_acc;

	assign out_free = !out_vld_q || !out_stall;
	assign s1_fire  = s1_vld_q && out_free;
	assign in_stall = s1_vld_q && !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration and PC
	logic [31:0] pc_q;
	logic [30:0] prog_words_q;

	// Register file memory and per-entry valid bits
	logic [31:0]          rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;

	// Source fields of the incoming instruction
	logic [4:0] rs1_in;
	logic [4:0] rs2_in;
	logic       rs1_ok;
	logic       rs2_ok;

	assign rs1_in = instruction_word[19:15];
	assign rs2_in = instruction_word[24:20];
	assign rs1_ok = (rs1_in != 5'd0) && ({1'b0, rs1_in} < REG_LIMIT);
	assign rs2_ok = (rs2_in != 5'd0) && ({1'b0, rs2_in} < REG_LIMIT);

	// Execute stage registers
	logic [31:0] instr_s1;
	logic [31:0] rd_a_s1;
	logic [31:0] rd_b_s1;
	logic        ok_a_s1;
	logic        ok_b_s1;
	logic        fwd_a_s1;
	logic        fwd_b_s1;
	logic [31:0] fwd_val_s1;

	// Writeback from the execute stage
	rv32se_pkg::exec_res_t res;
	logic                  wb_en;
	logic [IDX_W-1:0]      wb_idx;

	assign wb_en  = s1_fire && res.write_enable;
	assign wb_idx = res.write_index[IDX_W-1:0];

	// Operand read: registered data, plus forward flags for a write landing this edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1   <= instruction_word;
			rd_a_s1    <= rf_mem[rs1_in[IDX_W-1:0]];
			rd_b_s1    <= rf_mem[rs2_in[IDX_W-1:0]];
			ok_a_s1    <= rs1_ok && rf_vld_q[rs1_in[IDX_W-1:0]];
			ok_b_s1    <= rs2_ok && rf_vld_q[rs2_in[IDX_W-1:0]];
			fwd_a_s1   <= rs1_ok && wb_en && (res.write_index == rs1_in);
			fwd_b_s1   <= rs2_ok && wb_en && (res.write_index == rs2_in);
			fwd_val_s1 <= res.write_value;
		end
	end

	// Register file write port
	always_ff @(posedge clk) begin
		if (wb_en) begin
			rf_mem[wb_idx] <= res.write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wb_en) begin
			rf_vld_q[wb_idx] <= 1'b1;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_fire) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_fire) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// PC and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= '0;
			prog_words_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rv32se_pkg::CFG_START_ADDRESS: pc_q <= cfg_data;
				rv32se_pkg::CFG_PROGRAM_WORDS: prog_words_q <= cfg_data[30:0];
				default: ;
			endcase
		end else if (s1_fire) begin
			pc_q <= res.next_pc;
		end
	end

	// Execute: decode, ALU, branch compare and result assembly
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] imm_i;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] pc_plus4;
	logic        wr;
	logic        cond;
	logic [31:0] val;

	always_comb begin
		op_a = fwd_a_s1 ? fwd_val_s1 : (ok_a_s1 ? rd_a_s1 : 32'd0);
		op_b = fwd_b_s1 ? fwd_val_s1 : (ok_b_s1 ? rd_b_s1 : 32'd0);
		opc  = instr_s1[6:0];
		f3   = instr_s1[14:12];
		f7   = instr_s1[31:25];
		rd   = instr_s1[11:7];
		imm_i = {{20{instr_s1[31]}}, instr_s1[31:20]};
		imm_b = {{19{instr_s1[31]}}, instr_s1[31], instr_s1[7], instr_s1[30:25],
			instr_s1[11:8], 1'b0};
		imm_j = {{11{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
			instr_s1[30:21], 1'b0};
		pc_plus4 = pc_q + 32'd4;

		res = '0;
		res.next_pc = pc_plus4;
		wr   = 1'b0;
		cond = 1'b0;
		val  = 32'd0;

		case (opc)
			rv32se_pkg::OPC_R: begin
				wr = 1'b1;
				if (f3 == rv32se_pkg::F3_ADD && f7 == rv32se_pkg::F7_BASE) begin
					val = op_a + op_b;
				end else if (f3 == rv32se_pkg::F3_ADD && f7 == rv32se_pkg::F7_SUB) begin
					val = op_a - op_b;
				end else if (f3 == rv32se_pkg::F3_AND && f7 == rv32se_pkg::F7_BASE) begin
					val = op_a & op_b;
				end else if (f3 == rv32se_pkg::F3_OR && f7 == rv32se_pkg::F7_BASE) begin
					val = op_a | op_b;
				end else if (f3 == rv32se_pkg::F3_XOR && f7 == rv32se_pkg::F7_BASE) begin
					val = op_a ^ op_b;
				end else begin
					wr = 1'b0;
					res.unsupported = 1'b1;
				end
			end
			rv32se_pkg::OPC_I: begin
				wr = 1'b1;
				case (f3)
					rv32se_pkg::F3_ADD: val = op_a + imm_i;
					rv32se_pkg::F3_AND: val = op_a & imm_i;
					rv32se_pkg::F3_OR:  val = op_a | imm_i;
					rv32se_pkg::F3_XOR: val = op_a ^ imm_i;
					default: begin
						wr = 1'b0;
						res.unsupported = 1'b1;
					end
				endcase
			end
			rv32se_pkg::OPC_B: begin
				case (f3)
					rv32se_pkg::F3_BEQ: cond = (op_a == op_b);
					rv32se_pkg::F3_BNE: cond = (op_a != op_b);
					rv32se_pkg::F3_BLT: cond = ($signed(op_a) < $signed(op_b));
					rv32se_pkg::F3_BGE: cond = ($signed(op_a) >= $signed(op_b));
					default: res.unsupported = 1'b1;
				endcase
				if (cond) begin
					res.branch_taken = 1'b1;
					res.next_pc = pc_q + imm_b;
				end
			end
			rv32se_pkg::OPC_J: begin
				wr = 1'b1;
				val = pc_plus4;
				res.branch_taken = 1'b1;
				res.next_pc = pc_q + imm_j;
			end
			default: res.unsupported = 1'b1;
		endcase

		// x0 and registers beyond the file drop the write
		if (wr && rd != 5'd0 && {1'b0, rd} < REG_LIMIT) begin
			res.write_enable = 1'b1;
			res.write_index  = rd;
			res.write_value  = val;
		end

		res.done_res = {1'b0, res.next_pc[31:2]} >= prog_words_q;
	end

	// Result register
	rv32se_pkg::exec_res_t res_q;

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_vld_q;
	assign next_pc      = res_q.next_pc;
	assign write_enable = res_q.write_enable;
	assign write_index  = res_q.write_index;
	assign write_value  = res_q.write_value;
	assign branch_taken = res_q.branch_taken;
	assign unsupported  = res_q.unsupported;
	assign done_res     = res_q.done_res;

	// Checks
	a_wr_not_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> write_index != 5'd0)
		else $error("register write reported for x0");

	a_no_wr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_index == 5'd0 && write_value == 32'd0)
		else $error("write fields not cleared without a write");

	a_bad_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> !write_enable && !branch_taken)
		else $error("unsupported instruction had an effect");

	a_wb_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |=> rf_vld_q[$past(wb_idx)])
		else $error("register file entry not marked valid after write");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_vld_q && out_vld_q)
		else $error("input stalled with execute stage free");

endmodule

@@ tb/sv/rv32i_subset_executor_core_tb.sv @@
`timescale 1ns / 1ps

module rv32i_subset_executor_core_tb;

	localparam int REGS       = rv32se_pkg::REG_COUNT_DEF;
	localparam int LONG_HOLD  = 150;
	localparam int PHASE_LEN  = 320;
	localparam int TAIL_WAIT  = 8;

	logic                             clk              = 1'b0;
	logic                             arst_n           = 1'b0;
	logic                             in_valid         = 1'b0;
	logic                             in_stall;
	logic [31:0]                      instruction_word = '0;
	logic                             out_valid;
	logic                             out_stall        = 1'b0;
	logic [31:0]                      next_pc;
	logic                             write_enable;
	logic [4:0]                       write_index;
	logic [31:0]                      write_value;
	logic                             branch_taken;
	logic                             unsupported;
	logic                             done_res;
	logic                             cfg_valid        = 1'b0;
	logic                             cfg_ready;
	logic [rv32se_pkg::CFG_IDX_W-1:0] cfg_index        = rv32se_pkg::CFG_START_ADDRESS;
	logic [31:0]                      cfg_data         = '0;

	// Stimulus and scoreboard state
	logic [31:0]           insn_q[$];
	rv32se_pkg::exec_res_t retire_q[$];
	int                    accepted_cnt  = 0;
	int                    mismatches    = 0;
	logic                  in_acc        = 1'b0;
	int                    send_idle_pct = 0;
	int                    stall_pct     = 0;
	logic                  drain_pause   = 1'b0;
	logic                  hold_req      = 1'b0;
	logic                  hold_fired    = 1'b0;
	int                    hold_left     = 0;

	// Architectural state of the predictor
	logic [31:0] gpr [REGS];
	logic [31:0] pc_model;
	logic [30:0] cfg_words;

	rv32i_subset_executor_core #(
		.REG_COUNT(REGS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction_word(instruction_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_pc(next_pc),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_value(write_value),
		.branch_taken(branch_taken),
		.unsupported(unsupported),
		.done_res(done_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Instruction encoders
	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, rv32se_pkg::OPC_R};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
			input logic [2:0] f3, input logic [4:0] rd);
		return {imm, rs1, f3, rd, rv32se_pkg::OPC_I};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rv32se_pkg::OPC_B};
	endfunction

	function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32se_pkg::OPC_J};
	endfunction

	// At least half the picks land in x0..x3 so operands collide and branches compare equal
	function automatic logic [4:0] pick_reg();
		logic [4:0] r;
		if ($urandom_range(0, 1) == 0) begin
			r = 5'($urandom_range(0, 3));
		end else begin
			r = 5'($urandom_range(0, 31));
		end
		return r;
	endfunction

	// Mostly well-formed instructions, with raw noise and bad funct fields
	function automatic logic [31:0] random_insn();
		int          kind;
		int          k;
		logic [2:0]  f3;
		logic [31:0] rnd;
		kind = $urandom_range(0, 99);
		k    = $urandom_range(0, 3);
		rnd  = $urandom();
		case (k)
			0: f3 = rv32se_pkg::F3_ADD;
			1: f3 = rv32se_pkg::F3_XOR;
			2: f3 = rv32se_pkg::F3_OR;
			default: f3 = rv32se_pkg::F3_AND;
		endcase
		if (kind < 12) begin
			return rnd;
		end else if (kind < 36) begin
			if (rnd[0] && f3 == rv32se_pkg::F3_ADD) begin
				return enc_r(rv32se_pkg::F7_SUB, pick_reg(), pick_reg(),
					rv32se_pkg::F3_ADD, pick_reg());
			end
			return enc_r(rv32se_pkg::F7_BASE, pick_reg(), pick_reg(), f3, pick_reg());
		end else if (kind < 60) begin
			return enc_i(rnd[31:20], pick_reg(), f3, pick_reg());
		end else if (kind < 82) begin
			case (k)
				0: f3 = rv32se_pkg::F3_BEQ;
				1: f3 = rv32se_pkg::F3_BNE;
				2: f3 = rv32se_pkg::F3_BLT;
				default: f3 = rv32se_pkg::F3_BGE;
			endcase
			return enc_b({rnd[31:20], 1'b0}, pick_reg(), pick_reg(), f3);
		end else if (kind < 90) begin
			return enc_j({rnd[31:12], 1'b0}, pick_reg());
		end else if (kind < 94) begin
			// R type with arbitrary funct7/funct3, mostly outside the subset
			return enc_r(rnd[31:25], pick_reg(), pick_reg(), rnd[14:12], pick_reg());
		end else if (kind < 97) begin
			// I type funct3 among 1, 2, 3, 5
			f3 = (k == 0) ? 3'd5 : 3'(k);
			return enc_i(rnd[31:20], pick_reg(), f3, pick_reg());
		end
		// branch funct3 among 2, 3, 6, 7
		f3 = {rnd[1], 1'b1, rnd[0]};
		return enc_b({rnd[31:20], 1'b0}, pick_reg(), pick_reg(), f3);
	endfunction

	function automatic logic [31:0] read_gpr(input logic [4:0] idx);
		return (idx == 5'd0 || idx >= REGS) ? 32'd0 : gpr[idx];
	endfunction

	// Predicts one retirement and advances the architectural state
	function automatic rv32se_pkg::exec_res_t execute_insn(input logic [31:0] w);
		rv32se_pkg::exec_res_t r;
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm;
		logic [31:0] npc;
		logic [31:0] val;
		logic        wr;
		logic        taken;
		logic        bad;
		logic        cond;
		opc   = w[6:0];
		f3    = w[14:12];
		f7    = w[31:25];
		rd    = w[11:7];
		a     = read_gpr(w[19:15]);
		b     = read_gpr(w[24:20]);
		npc   = pc_model + 32'd4;
		val   = '0;
		wr    = 1'b0;
		taken = 1'b0;
		bad   = 1'b0;
		cond  = 1'b0;
		case (opc)
			rv32se_pkg::OPC_R: begin
				wr = 1'b1;
				if (f7 == rv32se_pkg::F7_BASE && f3 == rv32se_pkg::F3_ADD)
					val = a + b;
				else if (f7 == rv32se_pkg::F7_SUB && f3 == rv32se_pkg::F3_ADD)
					val = a - b;
				else if (f7 == rv32se_pkg::F7_BASE && f3 == rv32se_pkg::F3_AND)
					val = a & b;
				else if (f7 == rv32se_pkg::F7_BASE && f3 == rv32se_pkg::F3_OR)
					val = a | b;
				else if (f7 == rv32se_pkg::F7_BASE && f3 == rv32se_pkg::F3_XOR)
					val = a ^ b;
				else begin
					wr  = 1'b0;
					bad = 1'b1;
				end
			end
			rv32se_pkg::OPC_I: begin
				imm = {{20{w[31]}}, w[31:20]};
				wr  = 1'b1;
				case (f3)
					rv32se_pkg::F3_ADD: val = a + imm;
					rv32se_pkg::F3_AND: val = a & imm;
					rv32se_pkg::F3_OR:  val = a | imm;
					rv32se_pkg::F3_XOR: val = a ^ imm;
					default: begin
						wr  = 1'b0;
						bad = 1'b1;
					end
				endcase
			end
			rv32se_pkg::OPC_B: begin
				imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				case (f3)
					rv32se_pkg::F3_BEQ: cond = (a == b);
					rv32se_pkg::F3_BNE: cond = (a != b);
					rv32se_pkg::F3_BLT: cond = ($signed(a) < $signed(b));
					rv32se_pkg::F3_BGE: cond = ($signed(a) >= $signed(b));
					default: bad = 1'b1;
				endcase
				if (cond) begin
					taken = 1'b1;
					npc   = pc_model + imm;
				end
			end
			rv32se_pkg::OPC_J: begin
				imm   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
				wr    = 1'b1;
				val   = pc_model + 32'd4;
				taken = 1'b1;
				npc   = pc_model + imm;
			end
			default: bad = 1'b1;
		endcase
		// x0 and out-of-range destinations swallow the write
		if (wr && (rd == 5'd0 || rd >= REGS)) wr = 1'b0;
		if (wr) begin
			gpr[rd] = val;
		end else begin
			rd  = '0;
			val = '0;
		end
		pc_model       = npc;
		r.next_pc      = npc;
		r.write_enable = wr;
		r.write_index  = rd;
		r.write_value  = val;
		r.branch_taken = taken;
		r.unsupported  = bad;
		r.done_res     = ({1'b0, npc[31:2]} >= cfg_words);
		return r;
	endfunction

	// Request driver: holds a stalled request, otherwise offers the next one or idles
	always @(negedge clk) begin
		if (in_valid && !in_acc) begin
			in_valid <= 1'b1;
		end else if (insn_q.size() != 0 && !drain_pause
				&& $urandom_range(0, 99) >= send_idle_pct) begin
			in_valid         <= 1'b1;
			instruction_word <= insn_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Long result back-pressure, one shot
	always @(negedge clk) begin
		if (hold_req && !hold_fired) begin
			hold_fired <= 1'b1;
			hold_left  <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
	end

	// Monitor: checks results, tracks config writes, predicts accepted requests
	always @(posedge clk) begin
		rv32se_pkg::exec_res_t got;
		rv32se_pkg::exec_res_t want;
		if (arst_n) begin
			in_acc <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				got.next_pc      = next_pc;
				got.write_enable = write_enable;
				got.write_index  = write_index;
				got.write_value  = write_value;
				got.branch_taken = branch_taken;
				got.unsupported  = unsupported;
				got.done_res     = done_res;
				if (retire_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: next_pc %h we %b idx %0d val %h",
							next_pc, write_enable, write_index, write_value);
				end else begin
					want = retire_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp/act: next_pc %h/%h we %b/%b idx %0d/%0d",
								" val %h/%h br %b/%b unsup %b/%b done %b/%b"},
								want.next_pc, got.next_pc, want.write_enable,
								got.write_enable, want.write_index, got.write_index,
								want.write_value, got.write_value, want.branch_taken,
								got.branch_taken, want.unsupported, got.unsupported,
								want.done_res, got.done_res);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rv32se_pkg::CFG_START_ADDRESS) begin
					pc_model = cfg_data;
				end else if (cfg_index == rv32se_pkg::CFG_PROGRAM_WORDS) begin
					cfg_words = cfg_data[30:0];
				end
			end
			if (in_valid && !in_stall) begin
				retire_q.push_back(execute_insn(instruction_word));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	task automatic write_cfg(input logic [rv32se_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every request is taken and every result is back, then a short margin
	task automatic wait_idle();
		while (insn_q.size() != 0 || in_valid || retire_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int          base;
		logic [31:0] start;
		logic [31:0] words;
		for (int i = 0; i < REGS; i++) gpr[i] = '0;
		pc_model  = '0;
		cfg_words = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass on reset settings (start 0, zero program length)
		insn_q.push_back(enc_i(12'h7FF, 5'd0, rv32se_pkg::F3_ADD, 5'd1));
		insn_q.push_back(enc_i(12'h800, 5'd0, rv32se_pkg::F3_ADD, 5'd2));
		insn_q.push_back(enc_i(12'hFFF, 5'd1, rv32se_pkg::F3_ADD, 5'd3));
		insn_q.push_back(enc_i(12'h555, 5'd2, rv32se_pkg::F3_XOR, 5'd4));
		insn_q.push_back(enc_i(12'h800, 5'd3, rv32se_pkg::F3_OR, 5'd5));
		insn_q.push_back(enc_i(12'h0F0, 5'd5, rv32se_pkg::F3_AND, 5'd6));
		insn_q.push_back(enc_r(rv32se_pkg::F7_BASE, 5'd2, 5'd1,
			rv32se_pkg::F3_ADD, 5'd7));
		insn_q.push_back(enc_r(rv32se_pkg::F7_SUB, 5'd1, 5'd2,
			rv32se_pkg::F3_ADD, 5'd8));
		insn_q.push_back(enc_r(rv32se_pkg::F7_BASE, 5'd5, 5'd4,
			rv32se_pkg::F3_AND, 5'd9));
		insn_q.push_back(enc_r(rv32se_pkg::F7_BASE, 5'd2, 5'd4,
			rv32se_pkg::F3_OR, 5'd10));
		insn_q.push_back(enc_r(rv32se_pkg::F7_BASE, 5'd4, 5'd3,
			rv32se_pkg::F3_XOR, 5'd11));
		// write to x0 is dropped, read of x0 gives zero
		insn_q.push_back(enc_i(12'h005, 5'd1, rv32se_pkg::F3_ADD, 5'd0));
		insn_q.push_back(enc_r(rv32se_pkg::F7_BASE, 5'd1, 5'd0,
			rv32se_pkg::F3_ADD, 5'd12));
		insn_q.push_back(enc_b(13'h0008, 5'd1, 5'd1, rv32se_pkg::F3_BEQ));
		insn_q.push_back(enc_b(13'h0008, 5'd1, 5'd1, rv32se_pkg::F3_BNE));
		// negative offset, signed compare of a negative operand
		insn_q.push_back(enc_b(13'h1FFC, 5'd1, 5'd2, rv32se_pkg::F3_BLT));
		insn_q.push_back(enc_b(13'h0FFE, 5'd2, 5'd1, rv32se_pkg::F3_BGE));
		insn_q.push_back(enc_b(13'h0010, 5'd2, 5'd1, rv32se_pkg::F3_BLT));
		insn_q.push_back(enc_b(13'h1000, 5'd0, 5'd0, rv32se_pkg::F3_BEQ));
		insn_q.push_back(enc_j(21'h0FFFFE, 5'd1));
		insn_q.push_back(enc_j(21'h100000, 5'd31));
		insn_q.push_back(enc_j(21'h000008, 5'd0));
		// outside the subset
		insn_q.push_back(enc_r(7'h01, 5'd1, 5'd2, rv32se_pkg::F3_ADD, 5'd13));
		insn_q.push_back(enc_i(12'h001, 5'd1, 3'd1, 5'd14));
		insn_q.push_back(enc_b(13'h0008, 5'd1, 5'd1, 3'd2));
		insn_q.push_back(32'h0000_0000);
		insn_q.push_back(32'hFFFF_FFFF);
		wait_idle();

		// Random phases: none idle, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					start = 32'h0000_1000;
					words = 32'd1100;
				end
				1: begin
					start = 32'hFFFF_FFFC;
					words = 32'h4000_0000;
				end
				2: begin
					start = 32'h0000_0000;
					words = 32'h0000_0000;
				end
				default: begin
					start = $urandom();
					if (start > 32'hFFFF_FFFC) start = 32'hFFFF_FFFC;
					words = (start >> 2) + $urandom_range(0, 64);
					if (words > 32'h4000_0000) words = 32'h4000_0000;
				end
			endcase
			@(posedge clk);
			send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 29 : 0;
			stall_pct     = (ph == 2) ? 64 : (ph == 3) ? 29 : 0;
			write_cfg(rv32se_pkg::CFG_START_ADDRESS, start);
			write_cfg(rv32se_pkg::CFG_PROGRAM_WORDS, words);
			for (int n = 0; n < PHASE_LEN; n++) insn_q.push_back(random_insn());
			if (ph == 0) begin
				base = accepted_cnt;
				while (accepted_cnt < base + 80) @(negedge clk);
				@(posedge clk) hold_req = 1'b1;
				while (accepted_cnt < base + 220) @(negedge clk);
				@(posedge clk) drain_pause = 1'b1;
				while (in_valid || retire_q.size() != 0) @(negedge clk);
				@(posedge clk) drain_pause = 1'b0;
			end
			wait_idle();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (retire_q.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("PASS rv32i_subset_executor_core");
		end else begin
			$display("FAIL rv32i_subset_executor_core");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("FAIL rv32i_subset_executor_core");
		$finish;
	end

endmodule
